// ----- src/int_key_hybrid_hash_table_top_assert.svh -----
// ----------------------------------------------------------------------------
// int_key_hybrid_hash_table_top_assert.svh
// Assertion macros for the integer key hash table.
// ----------------------------------------------------------------------------
`ifndef INT_KEY_HYBRID_HASH_TABLE_TOP_ASSERT_SVH
`define INT_KEY_HYBRID_HASH_TABLE_TOP_ASSERT_SVH
`ifndef SYNTH
`define IKHT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define IKHT_ASSERT_NORST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define IKHT_ASSERT(lbl, prop, msg)
`define IKHT_ASSERT_NORST(lbl, prop, msg)
`endif
`endif

// ----- src/ikht_pkg.sv -----
// ----------------------------------------------------------------------------
// ikht_pkg
// Shared types and constants of the integer key hash table.
// ----------------------------------------------------------------------------
package ikht_pkg;

    localparam int KEY_W = 32;

    typedef enum logic [1:0] {
        REQ_LOOKUP = 2'd0,
        REQ_STORE  = 2'd1,
        REQ_CLEAR  = 2'd2,
        REQ_NEXT   = 2'd3
    } t_req;

    localparam logic [1:0] CFG_ARRAY_SIZE = 2'd0;
    localparam logic [1:0] CFG_HASH_SIZE  = 2'd1;
    localparam int         CFG_RST_SIZE   = 64;
    localparam logic [7:0] CUR_DONE       = 8'hFF;

    // magnitude of a two's complement key, most negative value maps to 2^31
    function automatic logic [KEY_W-1:0] key_mag(input logic [KEY_W-1:0] k);
        key_mag = k[KEY_W-1] ? (~k + KEY_W'(1)) : k;
    endfunction

endpackage

// ----- src/ikht_ram.sv -----
// ----------------------------------------------------------------------------
// ikht_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module ikht_ram #(
    parameter int W = 8,
    parameter int D = 16,
    localparam int IW = (D > 1) ? $clog2(D) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [IW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic [IW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/ikht_mod.sv -----
// ----------------------------------------------------------------------------
// ikht_mod
// Restoring remainder unit, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module ikht_mod import ikht_pkg::*; #(
    parameter int DW = 7
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [KEY_W-1:0] i_dividend,
    input  logic [DW-1:0]    i_divisor,
    output logic             o_done,
    output logic [DW-1:0]    o_rem
);

    localparam int CW = $clog2(KEY_W + 1);

    logic [CW-1:0]    r_cnt;
    logic             r_run;
    logic             r_done;
    logic [KEY_W-1:0] r_q;
    logic [DW-1:0]    r_rem;
    logic [DW:0]      trial;
    logic [DW:0]      diff;
    logic             ge;

    assign trial = {r_rem, r_q[KEY_W-1]};
    assign ge    = trial >= {1'b0, i_divisor};
    assign diff  = trial - {1'b0, i_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_q   <= i_dividend;
                r_rem <= '0;
                r_cnt <= CW'(KEY_W);
                r_run <= 1'b1;
            end else if (r_run) begin
                r_rem <= ge ? diff[DW-1:0] : trial[DW-1:0];
                r_q   <= r_q << 1;
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// ----- src/int_key_hybrid_hash_table_top.sv -----
// ----------------------------------------------------------------------------
// int_key_hybrid_hash_table_top: integer key table, array part + chained hash
// One request at a time, taken while idle; the result strobe cannot be held off.
// Array requests use the array RAM; iteration checks one position at a time. Hash
// requests take the home modulo (one bit per cycle), read each chain node, free-scan
// node and home; an occupied home adds its key's modulo, then a link or a move walk.
// Reset, clear and size config writes sweep max(ARRAY_DEPTH, HASH_DEPTH) addresses.
// ----------------------------------------------------------------------------
`include "int_key_hybrid_hash_table_top_assert.svh"

module int_key_hybrid_hash_table_top import ikht_pkg::*; #(
    parameter int ARRAY_DEPTH = 64,
    parameter int HASH_DEPTH  = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  logic [1:0]         i_req_type,
    input  logic signed [31:0] i_key,
    input  logic signed [31:0] i_value,
    input  logic               i_value_nil,
    input  logic signed [7:0]  i_cursor,
    output logic               o_done,
    output logic               o_found,
    output logic signed [31:0] o_out_value,
    output logic signed [31:0] o_out_key,
    output logic signed [7:0]  o_next_cursor,
    output logic               o_table_full,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [6:0]         i_cfg_data
);

    localparam int AIW    = (ARRAY_DEPTH > 1) ? $clog2(ARRAY_DEPTH) : 1;
    localparam int HIW    = (HASH_DEPTH > 1) ? $clog2(HASH_DEPTH) : 1;
    localparam int ASW    = $clog2(ARRAY_DEPTH + 1);
    localparam int HSW    = $clog2(HASH_DEPTH + 1);
    localparam int LW     = HIW + 1;
    localparam int NW     = LW + 2 * KEY_W + 2;
    localparam int MAXD   = (ARRAY_DEPTH > HASH_DEPTH) ? ARRAY_DEPTH : HASH_DEPTH;
    localparam int CLW    = $clog2(MAXD + 1);
    localparam int PW     = $clog2(ARRAY_DEPTH + HASH_DEPTH + 256) + 1;
    localparam int L_VP   = LW;
    localparam int L_VAL  = LW + 1;
    localparam int L_USED = LW + KEY_W + 1;
    localparam int L_KEY  = LW + KEY_W + 2;
    localparam int AS_RST = (CFG_RST_SIZE > ARRAY_DEPTH) ? ARRAY_DEPTH : CFG_RST_SIZE;
    localparam int HS_RST = (CFG_RST_SIZE > HASH_DEPTH) ? HASH_DEPTH : CFG_RST_SIZE;
    localparam logic [LW-1:0] LINK_NULL = LW'(1) << HIW;

    typedef enum logic [4:0] {
        S_IDLE, S_CLR, S_DISP, S_ACHK, S_H0, S_MOD1, S_FRD, S_FCHK,
        S_FREE, S_FREE_CHK, S_MPRD, S_MPCHK, S_O0, S_MOD2, S_PUSH, S_PUSH2,
        S_MOVE, S_WRD, S_WCHK, S_MPW, S_ITA, S_ITA_CHK, S_ITH, S_ITH_CHK
    } t_state;

    t_state           r_state;
    t_req             r_req;
    logic [KEY_W-1:0] r_key;
    logic [31:0]      r_value;
    logic             r_nil;
    logic [PW-1:0]    r_pos;
    logic [HIW-1:0]   r_ptr;
    logic [HIW-1:0]   r_home;
    logic [HIW-1:0]   r_fn;
    logic [HIW-1:0]   r_other;
    logic [HSW-1:0]   r_free;
    logic [NW-1:0]    r_mpw;
    logic [CLW-1:0]   r_clr;
    logic             r_clr_ack;
    logic [ASW-1:0]   r_as;
    logic [HSW-1:0]   r_hs;
    logic             r_done;
    logic             r_found;
    logic [31:0]      r_oval;
    logic [31:0]      r_okey;
    logic [7:0]       r_ncur;
    logic             r_full;

    // array RAM: {present, value}
    logic             ar_we;
    logic [AIW-1:0]   ar_waddr;
    logic [32:0]      ar_wdata;
    logic [AIW-1:0]   ar_raddr;
    logic [32:0]      ar_rdata;

    // node RAM: {key, used, value, present, link}
    logic             nd_we;
    logic [HIW-1:0]   nd_waddr;
    logic [NW-1:0]    nd_wdata;
    logic [HIW-1:0]   nd_raddr;
    logic [NW-1:0]    nd_rdata;

    logic             mod_start;
    logic [KEY_W-1:0] mod_dvd;
    logic             mod_done;
    logic [HSW-1:0]   mod_rem;

    logic [KEY_W-1:0] d_key;
    logic             d_used;
    logic [31:0]      d_val;
    logic             d_vp;
    logic [LW-1:0]    d_link;
    logic             d_hit;
    logic             walk_end;
    logic             in_arr;
    logic [31:0]      st_val;
    logic [LW-1:0]    fn_link;
    logic [HSW-1:0]   free_m1;
    logic [PW-1:0]    pos_hash;
    logic [6:0]       cfg_hs_raw;
    logic [ASW-1:0]   cfg_as;
    logic [HSW-1:0]   cfg_hs;
    logic             cfg_acc;

    ikht_ram #(.W(33), .D(ARRAY_DEPTH)) u_array_ram (
        .i_clk   (i_clk),
        .i_we    (ar_we),
        .i_waddr (ar_waddr),
        .i_wdata (ar_wdata),
        .i_raddr (ar_raddr),
        .o_rdata (ar_rdata)
    );

    ikht_ram #(.W(NW), .D(HASH_DEPTH)) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (nd_we),
        .i_waddr (nd_waddr),
        .i_wdata (nd_wdata),
        .i_raddr (nd_raddr),
        .o_rdata (nd_rdata)
    );

    ikht_mod #(.DW(HSW)) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mod_start),
        .i_dividend (mod_dvd),
        .i_divisor  (r_hs),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

    assign d_key    = nd_rdata[L_KEY +: KEY_W];
    assign d_used   = nd_rdata[L_USED];
    assign d_val    = nd_rdata[L_VAL +: 32];
    assign d_vp     = nd_rdata[L_VP];
    assign d_link   = nd_rdata[LW-1:0];
    assign d_hit    = d_used && (d_key == r_key);
    assign walk_end = d_link[HIW] || (d_link[HIW-1:0] == r_home);
    assign in_arr   = !r_key[KEY_W-1] && (r_key < KEY_W'(r_as));
    assign st_val   = r_nil ? 32'd0 : r_value;
    assign fn_link  = {1'b0, r_fn};
    assign free_m1  = r_free - HSW'(1);
    assign pos_hash = r_pos + PW'(r_as);

    assign cfg_hs_raw = (i_cfg_data == 7'd0) ? 7'd1 : i_cfg_data;
    assign cfg_as = (32'(i_cfg_data) > 32'(ARRAY_DEPTH)) ? ASW'(ARRAY_DEPTH)
                                                         : ASW'(i_cfg_data);
    assign cfg_hs = (32'(cfg_hs_raw) > 32'(HASH_DEPTH)) ? HSW'(HASH_DEPTH)
                                                        : HSW'(cfg_hs_raw);

    assign o_busy      = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE) && !i_start;
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;

    assign mod_start = (r_state == S_H0) || (r_state == S_O0);
    assign mod_dvd   = (r_state == S_H0) ? key_mag(r_key) : key_mag(r_mpw[L_KEY +: KEY_W]);

    always_comb begin
        ar_we    = 1'b0;
        ar_waddr = r_key[AIW-1:0];
        ar_wdata = {!r_nil, st_val};
        ar_raddr = (r_state == S_ITA) ? r_pos[AIW-1:0] : r_key[AIW-1:0];
        case (r_state)
            S_CLR: begin
                ar_we    = 32'(r_clr) < 32'(ARRAY_DEPTH);
                ar_waddr = r_clr[AIW-1:0];
                ar_wdata = '0;
            end
            S_DISP: begin
                ar_we = in_arr && (r_req == REQ_STORE);
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        nd_we    = 1'b0;
        nd_waddr = r_ptr;
        nd_wdata = {r_key, 1'b1, st_val, !r_nil, LINK_NULL};
        case (r_state)
            S_ITH:   nd_raddr = r_pos[HIW-1:0];
            S_FREE:  nd_raddr = free_m1[HIW-1:0];
            S_MPRD:  nd_raddr = r_home;
            default: nd_raddr = r_ptr;
        endcase
        case (r_state)
            S_CLR: begin
                nd_we    = 32'(r_clr) < 32'(HASH_DEPTH);
                nd_waddr = r_clr[HIW-1:0];
                nd_wdata = {{(NW-LW){1'b0}}, LINK_NULL};
            end
            S_FCHK: begin
                nd_we    = d_hit && (r_req == REQ_STORE);
                nd_wdata = {d_key, d_used, st_val, !r_nil, d_link};
            end
            S_MPCHK: begin
                nd_we    = !d_vp;
                nd_waddr = r_home;
                nd_wdata = {r_key, 1'b1, st_val, !r_nil, d_link};
            end
            S_PUSH: begin
                nd_we    = 1'b1;
                nd_waddr = r_fn;
                nd_wdata = {r_key, 1'b1, st_val, !r_nil, r_mpw[LW-1:0]};
            end
            S_PUSH2: begin
                nd_we    = 1'b1;
                nd_waddr = r_home;
                nd_wdata = {r_mpw[NW-1:LW], fn_link};
            end
            S_MOVE: begin
                nd_we    = 1'b1;
                nd_waddr = r_fn;
                nd_wdata = r_mpw;
            end
            S_WCHK: begin
                nd_we    = walk_end;
                nd_wdata = {nd_rdata[NW-1:LW], fn_link};
            end
            S_MPW: begin
                nd_we    = 1'b1;
                nd_waddr = r_home;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_clr     <= '0;
            r_clr_ack <= 1'b0;
            r_as      <= ASW'(AS_RST);
            r_hs      <= HSW'(HS_RST);
            r_free    <= '0;
            r_done    <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_req     <= t_req'(i_req_type);
                        r_key     <= i_key;
                        r_value   <= i_value;
                        r_nil     <= i_value_nil;
                        r_pos     <= i_cursor[7] ? '0 : PW'(i_cursor[6:0]) + PW'(1);
                        r_found   <= 1'b0;
                        r_oval    <= '0;
                        r_okey    <= '0;
                        r_ncur    <= '0;
                        r_full    <= 1'b0;
                        r_clr     <= '0;
                        r_clr_ack <= 1'b1;
                        case (t_req'(i_req_type))
                            REQ_CLEAR: r_state <= S_CLR;
                            REQ_NEXT:  r_state <= S_ITA;
                            default:   r_state <= S_DISP;
                        endcase
                    end else if (cfg_acc) begin
                        r_clr     <= '0;
                        r_clr_ack <= 1'b0;
                        if (i_cfg_index == CFG_ARRAY_SIZE) begin
                            r_as    <= cfg_as;
                            r_state <= S_CLR;
                        end else if (i_cfg_index == CFG_HASH_SIZE) begin
                            r_hs    <= cfg_hs;
                            r_state <= S_CLR;
                        end
                    end
                end
                S_CLR: begin
                    r_clr <= r_clr + CLW'(1);
                    if (r_clr == CLW'(MAXD - 1)) begin
                        r_free  <= r_hs;
                        r_done  <= r_clr_ack;
                        r_state <= S_IDLE;
                    end
                end
                S_DISP: begin
                    if (in_arr) begin
                        if (r_req == REQ_STORE) begin
                            r_done  <= 1'b1;
                            r_state <= S_IDLE;
                        end else begin
                            r_state <= S_ACHK;
                        end
                    end else begin
                        r_state <= S_H0;
                    end
                end
                S_ACHK: begin
                    r_found <= ar_rdata[32];
                    r_oval  <= ar_rdata[32] ? ar_rdata[31:0] : 32'd0;
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                S_H0: begin
                    r_state <= S_MOD1;
                end
                S_MOD1: begin
                    if (mod_done) begin
                        r_home  <= mod_rem[HIW-1:0];
                        r_ptr   <= mod_rem[HIW-1:0];
                        r_state <= S_FRD;
                    end
                end
                S_FRD: begin
                    r_state <= S_FCHK;
                end
                S_FCHK: begin
                    if (d_hit) begin
                        if (r_req == REQ_LOOKUP) begin
                            r_found <= d_vp;
                            r_oval  <= d_vp ? d_val : 32'd0;
                        end
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end else if (d_link[HIW]) begin
                        if (r_req == REQ_LOOKUP) begin
                            r_done  <= 1'b1;
                            r_state <= S_IDLE;
                        end else begin
                            r_state <= S_FREE;
                        end
                    end else begin
                        r_ptr   <= d_link[HIW-1:0];
                        r_state <= S_FRD;
                    end
                end
                S_FREE: begin
                    if (r_free == '0) begin
                        r_full  <= 1'b1;
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_state <= S_FREE_CHK;
                    end
                end
                S_FREE_CHK: begin
                    if (!d_vp && !d_used) begin
                        r_fn    <= free_m1[HIW-1:0];
                        r_state <= S_MPRD;
                    end else begin
                        r_free  <= free_m1;
                        r_state <= S_FREE;
                    end
                end
                S_MPRD: begin
                    r_state <= S_MPCHK;
                end
                S_MPCHK: begin
                    r_mpw <= nd_rdata;
                    if (!d_vp) begin
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_state <= S_O0;
                    end
                end
                S_O0: begin
                    r_state <= S_MOD2;
                end
                S_MOD2: begin
                    if (mod_done) begin
                        r_other <= mod_rem[HIW-1:0];
                        r_state <= (mod_rem[HIW-1:0] != r_home) ? S_MOVE : S_PUSH;
                    end
                end
                S_PUSH: begin
                    r_state <= S_PUSH2;
                end
                S_PUSH2: begin
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                S_MOVE: begin
                    r_ptr   <= r_other;
                    r_state <= S_WRD;
                end
                S_WRD: begin
                    r_state <= S_WCHK;
                end
                S_WCHK: begin
                    // find the predecessor of the displaced node in its own chain
                    if (walk_end) begin
                        r_state <= S_MPW;
                    end else begin
                        r_ptr   <= d_link[HIW-1:0];
                        r_state <= S_WRD;
                    end
                end
                S_MPW: begin
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                S_ITA: begin
                    if (r_pos < PW'(r_as)) begin
                        r_state <= S_ITA_CHK;
                    end else begin
                        r_pos   <= r_pos - PW'(r_as);
                        r_state <= S_ITH;
                    end
                end
                S_ITA_CHK: begin
                    if (ar_rdata[32]) begin
                        r_found <= 1'b1;
                        r_okey  <= 32'(r_pos);
                        r_oval  <= ar_rdata[31:0];
                        r_ncur  <= r_pos[7:0];
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_pos   <= r_pos + PW'(1);
                        r_state <= S_ITA;
                    end
                end
                S_ITH: begin
                    if (r_pos < PW'(r_hs)) begin
                        r_state <= S_ITH_CHK;
                    end else begin
                        r_ncur  <= CUR_DONE;
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                S_ITH_CHK: begin
                    if (d_vp) begin
                        r_found <= 1'b1;
                        r_okey  <= d_key;
                        r_oval  <= d_val;
                        r_ncur  <= pos_hash[7:0];
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_pos   <= r_pos + PW'(1);
                        r_state <= S_ITH;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_done        = r_done;
    assign o_found       = r_found;
    assign o_out_value   = r_oval;
    assign o_out_key     = r_okey;
    assign o_next_cursor = r_ncur;
    assign o_table_full  = r_full;

    `IKHT_ASSERT(a_done_frees, o_done |-> !o_busy, "result strobe while still busy")
    `IKHT_ASSERT(a_start_busy, (i_start && !o_busy) |=> o_busy, "request not taken")
    `IKHT_ASSERT(a_cfg_clear,
        (cfg_acc && (i_cfg_index == CFG_ARRAY_SIZE || i_cfg_index == CFG_HASH_SIZE))
        |=> (o_busy && !o_done), "config write did not start a clear")
    `IKHT_ASSERT_NORST(a_rst_clear, !i_rst_n |=> (o_busy && !o_done),
        "reset did not start the clearing sweep")

endmodule
